// ----- rtl/flwc_pkg.sv -----
// Shared types and constants of the face-likeness window classifier.
package flwc_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH      = 3'd0,
      CSR_FRAME_HEIGHT     = 3'd1,
      CSR_MIN_AVG_BRIGHT   = 3'd2,
      CSR_MAX_AVG_BRIGHT   = 3'd3,
      CSR_MIN_SKIN_PERCENT = 3'd4,
      CSR_SKIN_MIN_LUMA    = 3'd5,
      CSR_SKIN_MAX_RG_GAP  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [10:0] frame_width;
      logic [10:0] frame_height;
      logic [7:0]  min_avg_brightness;
      logic [7:0]  max_avg_brightness;
      logic [6:0]  min_skin_percent;
      logic [7:0]  skin_min_luma;
      logic [7:0]  skin_max_red_green_gap;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_width:            11'd320,
      frame_height:           11'd240,
      min_avg_brightness:     8'd60,
      max_avg_brightness:     8'd200,
      min_skin_percent:       7'd18,
      skin_min_luma:          8'd80,
      skin_max_red_green_gap: 8'd80
   };

   typedef struct packed {
      logic [15:0] pixel;
      logic        frame_start;
   } req_type;

   typedef struct packed {
      logic        face_detected;
      logic [16:0] sample_count;
      logic [16:0] skin_count;
      logic [23:0] luma_sum;
   } rsp_type;

   // Word handed from the front end to the back end
   typedef struct packed {
      logic       sampled;
      logic       skin;
      logic [7:0] luma;
      logic       clear;
      logic       last;
   } sample_type;

   // Luma weights; the divide by 100 is a multiply by 5243 and a shift by 19,
   // exact for every weighted sum below 25037.
   localparam int LUMA_R_WEIGHT = 30;
   localparam int LUMA_G_WEIGHT = 59;
   localparam int LUMA_B_WEIGHT = 11;
   localparam int LUMA_RECIP    = 5243;
   localparam int LUMA_SHIFT    = 19;
   localparam int PERCENT_SCALE = 100;

   // Queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPW         = $clog2(QUEUE_DEPTH);
   localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- rtl/flwc_front.sv -----
// Front end: frame position tracking, window sampling, luma and skin classification.
module flwc_front import flwc_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic [QCW-1:0]   queue_count,
   output logic             push_valid,
   output sample_type       push_word
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [CW-1:0] col_ff, col_in, col_cur;
   logic [RW-1:0] row_ff, row_in, row_cur;
   logic [WW-1:0] width, width_lo, width_hi, width_last;
   logic [HW-1:0] height, height_lo, height_hi, height_last;
   logic          accept, col_sampled, row_sampled, col_end, row_end;
   logic [7:0]    red, green, blue;
   logic [14:0]   weighted;
   logic          colour_ok;
   logic [QCW:0]  in_flight;

   logic          s1_valid_ff, s1_valid_in;
   logic [14:0]   s1_weighted_ff;
   logic          s1_colour_ok_ff, s1_sampled_ff, s1_last_ff, s1_clear_ff;
   logic          s2_valid_ff, s2_valid_in;
   sample_type    s2_word_ff, s2_word_in;
   logic [27:0]   recip_product;
   logic [7:0]    luma;

   always_comb begin
      if (cfg.frame_width == '0) begin
         width = WW'(1);
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         width = WW'(MAX_WIDTH);
      end else begin
         width = WW'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         height = HW'(1);
      end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
         height = HW'(MAX_HEIGHT);
      end else begin
         height = HW'(cfg.frame_height);
      end
   end

   assign width_lo    = width >> 2;
   assign width_hi    = width - width_lo;
   assign width_last  = width - WW'(1);
   assign height_lo   = height >> 2;
   assign height_hi   = height - height_lo;
   assign height_last = height - HW'(1);

   assign in_flight = (QCW+1)'(queue_count) + (QCW+1)'(s1_valid_ff) + (QCW+1)'(s2_valid_ff);
   assign req_ready = in_flight < (QCW+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // Frame start forces the position back to the origin
   assign col_cur = req_data.frame_start ? '0 : col_ff;
   assign row_cur = req_data.frame_start ? '0 : row_ff;

   assign col_sampled = (WW'(col_cur) >= width_lo) && (WW'(col_cur) < width_hi)
                        && (col_cur[0] == width_lo[0]);
   assign row_sampled = (HW'(row_cur) >= height_lo) && (HW'(row_cur) < height_hi)
                        && (row_cur[0] == height_lo[0]);
   assign col_end = WW'(col_cur) >= width_last;
   assign row_end = HW'(row_cur) >= height_last;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_cur + RW'(1);
         end else begin
            col_in = col_cur + CW'(1);
            row_in = row_cur;
         end
      end
   end

   assign red   = {req_data.pixel[15:11], 3'b000};
   assign green = {req_data.pixel[10:5], 2'b00};
   assign blue  = {req_data.pixel[4:0], 3'b000};

   assign weighted = 15'(16'(red) * 16'(LUMA_R_WEIGHT) + 16'(green) * 16'(LUMA_G_WEIGHT)
                         + 16'(blue) * 16'(LUMA_B_WEIGHT));
   assign colour_ok = (red > green) && (green >= {1'b0, blue[7:1]})
                      && ((red - green) < cfg.skin_max_red_green_gap);

   assign recip_product = 28'(s1_weighted_ff) * 28'(LUMA_RECIP);
   assign luma          = recip_product[LUMA_SHIFT +: 8];

   always_comb begin
      s1_valid_in           = accept;
      s2_valid_in           = s1_valid_ff;
      s2_word_in.sampled    = s1_sampled_ff;
      s2_word_in.skin       = s1_colour_ok_ff && (luma > cfg.skin_min_luma);
      s2_word_in.luma       = luma;
      s2_word_in.clear      = s1_clear_ff;
      s2_word_in.last       = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_weighted_ff  <= weighted;
      s1_colour_ok_ff <= colour_ok;
      s1_sampled_ff   <= col_sampled && row_sampled;
      s1_last_ff      <= col_end && row_end;
      s1_clear_ff     <= req_data.frame_start;
      s2_word_ff      <= s2_word_in;
   end

   assign push_valid = s2_valid_ff;
   assign push_word  = s2_word_ff;

endmodule

// ----- rtl/flwc_queue.sv -----
// Short word queue that decouples the front end from the back end.
module flwc_queue import flwc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  sample_type     push_word,
   input  logic           pop_ready,
   output logic           head_valid,
   output sample_type     head_word,
   output logic [QCW-1:0] count
);

   sample_type     slot_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic           pop;

   assign head_valid = count_ff != '0;
   assign head_word  = slot_ff[rd_ptr_ff];
   assign pop        = head_valid && pop_ready;
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPW'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- rtl/flwc_back.sv -----
// Back end: frame accumulation, threshold compares and result register.
module flwc_back import flwc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       head_valid,
   input  sample_type head_word,
   output logic       pop_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic [16:0] acc_count_ff, acc_count_in, acc_skin_ff, acc_skin_in;
   logic [23:0] acc_luma_ff, acc_luma_in;
   logic [16:0] base_count, base_skin, next_count, next_skin;
   logic [23:0] base_luma, next_luma;
   logic [24:0] luma_wide;
   logic        pop;

   logic        f1_valid_ff, f1_valid_in;
   logic [16:0] f1_count_ff, f1_skin_ff;
   logic [23:0] f1_luma_ff;
   logic        f2_valid_ff, f2_valid_in;
   logic [16:0] f2_count_ff, f2_skin_ff;
   logic [23:0] f2_luma_ff;
   logic [24:0] f2_low_ff, f2_high_ff;
   logic [23:0] f2_skin_scaled_ff, f2_share_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;
   logic        out_load, f2_take, f1_move, f1_take;

   assign out_load  = f2_valid_ff && (!out_valid_ff || rsp_ready);
   assign f2_take   = !f2_valid_ff || out_load;
   assign f1_move   = f1_valid_ff && f2_take;
   assign f1_take   = !f1_valid_ff || f1_move;
   assign pop_ready = !head_word.last || f1_take;
   assign pop       = head_valid && pop_ready;

   assign base_count = head_word.clear ? '0 : acc_count_ff;
   assign base_skin  = head_word.clear ? '0 : acc_skin_ff;
   assign base_luma  = head_word.clear ? '0 : acc_luma_ff;
   assign luma_wide  = {1'b0, base_luma} + 25'(head_word.luma);

   // Add the sample with saturation
   always_comb begin
      next_count = base_count;
      next_skin  = base_skin;
      next_luma  = base_luma;
      if (head_word.sampled) begin
         next_count = (base_count == '1) ? base_count : base_count + 17'(1);
         next_luma  = luma_wide[24] ? '1 : luma_wide[23:0];
         if (head_word.skin) begin
            next_skin = (base_skin == '1) ? base_skin : base_skin + 17'(1);
         end
      end
   end

   always_comb begin
      acc_count_in = acc_count_ff;
      acc_skin_in  = acc_skin_ff;
      acc_luma_in  = acc_luma_ff;
      if (pop) begin
         acc_count_in = head_word.last ? '0 : next_count;
         acc_skin_in  = head_word.last ? '0 : next_skin;
         acc_luma_in  = head_word.last ? '0 : next_luma;
      end
      f1_valid_in  = (pop && head_word.last) ? 1'b1 : (f1_move ? 1'b0 : f1_valid_ff);
      f2_valid_in  = f1_move ? 1'b1 : (out_load ? 1'b0 : f2_valid_ff);
      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

      out_data_in.face_detected = (f2_count_ff != '0)
                                  && (25'(f2_luma_ff) >= f2_low_ff)
                                  && (25'(f2_luma_ff) <= f2_high_ff)
                                  && (f2_skin_scaled_ff >= f2_share_ff);
      out_data_in.sample_count  = f2_count_ff;
      out_data_in.skin_count    = f2_skin_ff;
      out_data_in.luma_sum      = f2_luma_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_count_ff <= '0;
         acc_skin_ff  <= '0;
         acc_luma_ff  <= '0;
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_count_ff <= acc_count_in;
         acc_skin_ff  <= acc_skin_in;
         acc_luma_ff  <= acc_luma_in;
         f1_valid_ff  <= f1_valid_in;
         f2_valid_ff  <= f2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_word.last) begin
         f1_count_ff <= next_count;
         f1_skin_ff  <= next_skin;
         f1_luma_ff  <= next_luma;
      end
      if (f1_move) begin
         f2_count_ff       <= f1_count_ff;
         f2_skin_ff        <= f1_skin_ff;
         f2_luma_ff        <= f1_luma_ff;
         f2_low_ff         <= 25'(f1_count_ff) * 25'(cfg.min_avg_brightness);
         f2_high_ff        <= 25'(f1_count_ff) * 25'(cfg.max_avg_brightness);
         f2_skin_scaled_ff <= 24'(f1_skin_ff) * 24'(PERCENT_SCALE);
         f2_share_ff       <= 24'(f1_count_ff) * 24'(cfg.min_skin_percent);
      end
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- rtl/face_likeness_window_classifier_unit.sv -----
// Top level of the face-likeness window classifier: configuration registers and datapath.
// Throughput: one pixel word per cycle; the front end takes a pixel while the queue has room.
// Path: after the last pixel of the frame is taken, its word passes two classify stages,
//    one queue slot and two compare stages into the result register.
// Reset: clears the position counters, sums, queue and valid flags and loads the
//    default frame size and thresholds; a held result is dropped.
module face_likeness_window_classifier_unit import flwc_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   logic           push_valid;
   sample_type     push_word;
   logic           head_valid;
   sample_type     head_word;
   logic           pop_ready;
   logic [QCW-1:0] q_count;

   // Register file: decode the index and take the low bits of the write word
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:      cfg_in.frame_width            = csr_wdata;
            CSR_FRAME_HEIGHT:     cfg_in.frame_height           = csr_wdata;
            CSR_MIN_AVG_BRIGHT:   cfg_in.min_avg_brightness     = csr_wdata[7:0];
            CSR_MAX_AVG_BRIGHT:   cfg_in.max_avg_brightness     = csr_wdata[7:0];
            CSR_MIN_SKIN_PERCENT: cfg_in.min_skin_percent       = csr_wdata[6:0];
            CSR_SKIN_MIN_LUMA:    cfg_in.skin_min_luma          = csr_wdata[7:0];
            CSR_SKIN_MAX_RG_GAP:  cfg_in.skin_max_red_green_gap = csr_wdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: track position, sample the central window, classify each sample
   flwc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .queue_count (q_count),
      .push_valid  (push_valid),
      .push_word   (push_word)
   );

   // Hold classified words while the back end waits on a stalled result
   flwc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pop_ready  (pop_ready),
      .head_valid (head_valid),
      .head_word  (head_word),
      .count      (q_count)
   );

   // Back end: accumulate per frame, compare against limits, present the result word
   flwc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_word  (head_word),
      .pop_ready  (pop_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // The credit check on the input side must keep the queue from overflowing
   assert property (@(posedge clock) disable iff (reset)
      q_count <= QCW'(QUEUE_DEPTH))
      else $error("word queue overflow");

   // A face needs at least one sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.face_detected |-> rsp_data.sample_count != '0)
      else $error("face reported for empty window");

   // Skin samples are a subset of all samples
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.skin_count <= rsp_data.sample_count)
      else $error("skin count exceeds sample count");
`endif

endmodule
